FILE: rtl/r30_pkg.sv
// ----------------------------------------------------------------------------
// r30_pkg
// Shared constants, types and command/status bundles for the Rule 30 ring
// random generator.
// ----------------------------------------------------------------------------
package r30_pkg;

	// ring geometry
	localparam int unsigned WIDTH      = 256;
	localparam int unsigned MID        = WIDTH / 2;
	localparam int unsigned TAP        = WIDTH / 8;
	localparam int unsigned WARM_STEPS = WIDTH / 2;
	localparam int unsigned SEED_CELLS = (WIDTH < 64) ? WIDTH : 64;
	localparam int unsigned MIX_CELLS  = WIDTH - SEED_CELLS;

	// generate requests
	localparam int unsigned MAX_BITS = 64;
	localparam int unsigned BCNT_W   = 7;
	localparam int unsigned CNT_W    = ($clog2(WIDTH + 1) > BCNT_W) ? $clog2(WIDTH + 1) : BCNT_W;

	// splitmix64 constants
	localparam logic [63:0] MIX_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] MIX_C1     = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] MIX_C2     = 64'h94D0_49BB_1331_11EB;
	localparam int unsigned MIX_SH1    = 30;
	localparam int unsigned MIX_SH2    = 27;
	localparam int unsigned MIX_SH3    = 31;

	// command codes
	localparam logic CMD_RESEED   = 1'b0;
	localparam logic CMD_GENERATE = 1'b1;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [BCNT_W-1:0] bcnt_t;

	typedef struct packed {
		logic init;
		logic run;
	} mix_cmd_t;

	typedef struct packed {
		logic bit_valid;
		logic bit_val;
	} mix_st_t;

	typedef struct packed {
		logic fill;
		logic load_seed;
		logic set_mid;
		logic step;
		logic gen;
		logic clr_acc;
		logic out_load;
	} ring_cmd_t;

	typedef struct packed {
		logic row_empty;
		logic all_one;
		logic out_full;
	} ring_st_t;

endpackage

FILE: rtl/rule30_ring_random_generator.sv
// ----------------------------------------------------------------------------
// rule30_ring_random_generator
// Rule 30 cellular automaton random bit generator on a ring of cells.
// ----------------------------------------------------------------------------
// One word in gives one word out. A generate word asking for n bits (n
// saturated at 64) steps the ring once per bit, one ring step per cycle, and
// loads the result once the output register is free; n = 0 returns 0. A
// reseed word costs one splitmix64 draw for every cell above the seed bits,
// run through a single shared 32x32 multiplier, then loads the seed, warms the
// ring up and warms it up again if the row dies in warm-up. A reseed returns 0.
// The input is taken only between words, but a new word is accepted while the
// previous result still waits in the output register. Write the seed only
// while the block is idle; it takes effect at the next reseed.
module rule30_ring_random_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [6:0]  bit_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] value
);

	logic [63:0]        seed_q;
	r30_pkg::ring_cmd_t ring_cmd;
	r30_pkg::ring_st_t  ring_st;
	r30_pkg::mix_cmd_t  mix_cmd;
	r30_pkg::mix_st_t   mix_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 64'h0;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	r30_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.bit_count  (bit_count),
		.out_stall  (out_stall),
		.ring_st_i  (ring_st),
		.mix_st_i   (mix_st),
		.ring_cmd_o (ring_cmd),
		.mix_cmd_o  (mix_cmd)
	);

	r30_mixer u_mixer (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_i  (mix_cmd),
		.seed   (seed_q),
		.st_o   (mix_st)
	);

	r30_ring u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_i     (ring_cmd),
		.seed      (seed_q),
		.mix_bit   (mix_st.bit_val),
		.out_stall (out_stall),
		.st_o      (ring_st),
		.out_valid (out_valid),
		.value     (value)
	);

	// never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ring_cmd.out_load |-> (!out_valid || !out_stall))
		else $error("output word overwritten while stalled");

	// one word at a time: busy straight after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted twice in a row");

	// mixer bits only arrive while the ring is being filled
	a_mix_bit_used: assert property (@(posedge clk) disable iff (!arst_n)
		mix_st.bit_valid |-> ring_cmd.fill)
		else $error("mixer bit produced outside fill");

endmodule

FILE: rtl/r30_mixer.sv
// ----------------------------------------------------------------------------
// r30_mixer
// splitmix64 sequencer producing the low output bit of each draw, using one
// shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module r30_mixer (
	input  logic              clk,
	input  logic              arst_n,
	input  r30_pkg::mix_cmd_t cmd_i,
	input  logic [63:0]       seed,
	output r30_pkg::mix_st_t  st_o
);

	typedef enum logic [6:0] {
		P_ADD = 7'b0000001,
		P_M0  = 7'b0000010,
		P_M1  = 7'b0000100,
		P_M2  = 7'b0001000,
		P_SUM = 7'b0010000,
		P_M3  = 7'b0100000,
		P_OUT = 7'b1000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [63:0] st_q;
	logic [63:0] a_q;
	logic [63:0] lo_q;
	logic [31:0] hi_q;
	logic [31:0] b_q;
	logic [63:0] mp_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [63:0] x_add, y_sum, b_mix;

	always_comb begin
		mul_a = a_q[31:0];
		mul_b = r30_pkg::MIX_C1[31:0];
		unique case (phase_q)
			P_M1: begin
				mul_b = r30_pkg::MIX_C1[63:32];
			end
			P_M2: begin
				mul_a = a_q[63:32];
			end
			P_M3: begin
				mul_a = b_q;
				mul_b = r30_pkg::MIX_C2[31:0];
			end
			default: begin
				mul_a = a_q[31:0];
				mul_b = r30_pkg::MIX_C1[31:0];
			end
		endcase
		mul_p = {32'h0, mul_a} * {32'h0, mul_b};
	end

	assign x_add = st_q + r30_pkg::MIX_GOLDEN;
	// only the low 64 bits of the first product matter
	assign y_sum = lo_q + {hi_q + mp_q[31:0], 32'h0};
	assign b_mix = y_sum ^ (y_sum >> r30_pkg::MIX_SH2);

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			P_ADD:   phase_d = P_M0;
			P_M0:    phase_d = P_M1;
			P_M1:    phase_d = P_M2;
			P_M2:    phase_d = P_SUM;
			P_SUM:   phase_d = P_M3;
			P_M3:    phase_d = P_OUT;
			P_OUT:   phase_d = P_ADD;
			default: phase_d = P_ADD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_ADD;
		end else if (cmd_i.init) begin
			phase_q <= P_ADD;
		end else if (cmd_i.run) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= 64'h0;
		end else if (cmd_i.init) begin
			st_q <= seed;
		end else if (cmd_i.run && phase_q == P_ADD) begin
			st_q <= x_add;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.run) begin
			unique case (phase_q)
				P_ADD: begin
					a_q <= x_add ^ (x_add >> r30_pkg::MIX_SH1);
				end
				P_M0: begin
					mp_q <= mul_p;
				end
				P_M1: begin
					lo_q <= mp_q;
					mp_q <= mul_p;
				end
				P_M2: begin
					hi_q <= mp_q[31:0];
					mp_q <= mul_p;
				end
				P_SUM: begin
					b_q <= b_mix[31:0];
				end
				P_M3: begin
					mp_q <= mul_p;
				end
				default: begin
				end
			endcase
		end
	end

	// low bit of z ^ (z >> 31) needs only the low 32 bits of the last product
	assign st_o.bit_valid = cmd_i.run && phase_q == P_OUT;
	assign st_o.bit_val   = mp_q[0] ^ mp_q[r30_pkg::MIX_SH3];

endmodule

FILE: rtl/r30_ring.sv
// ----------------------------------------------------------------------------
// r30_ring
// Cell ring with a combinational Rule 30 step into the row register, bit
// accumulator and output word register.
// ----------------------------------------------------------------------------
module r30_ring (
	input  logic               clk,
	input  logic               arst_n,
	input  r30_pkg::ring_cmd_t cmd_i,
	input  logic [63:0]        seed,
	input  logic               mix_bit,
	input  logic               out_stall,
	output r30_pkg::ring_st_t  st_o,
	output logic               out_valid,
	output logic [63:0]        value
);

	logic [r30_pkg::WIDTH-1:0] row_q, row_d;
	logic [r30_pkg::WIDTH-1:0] left, right, stepped;
	logic                      tap_bit;
	logic [63:0]               acc_q;
	logic                      out_valid_q;
	logic [63:0]               value_q;

	assign left    = {row_q[r30_pkg::WIDTH-2:0], row_q[r30_pkg::WIDTH-1]};
	assign right   = {row_q[0], row_q[r30_pkg::WIDTH-1:1]};
	assign stepped = left ^ (row_q | right);
	assign tap_bit = stepped[r30_pkg::MID] ^ stepped[r30_pkg::MID - r30_pkg::TAP]
		^ stepped[r30_pkg::MID + r30_pkg::TAP];

	always_comb begin
		row_d = row_q;
		if (cmd_i.fill) begin
			// shift in from the top: the first mixed bit lands just above the seed cells
			row_d = {mix_bit, row_q[r30_pkg::WIDTH-1:1]};
		end else if (cmd_i.load_seed) begin
			for (int i = 0; i < r30_pkg::SEED_CELLS; i++) begin
				row_d[i] = seed[i];
			end
		end else if (cmd_i.set_mid) begin
			row_d[r30_pkg::MID] = 1'b1;
		end else if (cmd_i.step || cmd_i.gen) begin
			row_d = stepped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else begin
			row_q <= row_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.clr_acc) begin
			acc_q <= 64'h0;
		end else if (cmd_i.gen) begin
			acc_q <= {acc_q[62:0], tap_bit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_i.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.out_load) begin
			value_q <= acc_q;
		end
	end

	assign st_o.row_empty = ~|row_q;
	assign st_o.all_one   = &row_q;
	assign st_o.out_full  = out_valid_q;
	assign out_valid      = out_valid_q;
	assign value          = value_q;

endmodule

FILE: rtl/r30_ctrl.sv
// ----------------------------------------------------------------------------
// r30_ctrl
// Sequencer for reseed (fill, load, fix, warm-up, dead-row check) and
// generate, plus the step counter.
// ----------------------------------------------------------------------------
module r30_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       cmd,
	input  logic [r30_pkg::BCNT_W-1:0] bit_count,
	input  logic                       out_stall,
	input  r30_pkg::ring_st_t          ring_st_i,
	input  r30_pkg::mix_st_t           mix_st_i,
	output r30_pkg::ring_cmd_t         ring_cmd_o,
	output r30_pkg::mix_cmd_t          mix_cmd_o
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_FILL   = 10'b0000000010,
		S_LOAD   = 10'b0000000100,
		S_FIX    = 10'b0000001000,
		S_WARM   = 10'b0000010000,
		S_CHECK  = 10'b0000100000,
		S_WARM2  = 10'b0001000000,
		S_STEP   = 10'b0010000000,
		S_FINISH = 10'b0100000000,
		S_SPARE  = 10'b1000000000
	} state_t;

	state_t              state_q, state_d;
	r30_pkg::cnt_t       cnt_q, cnt_d;
	r30_pkg::bcnt_t      req_bits;
	logic                cnt_last;

	assign req_bits = (bit_count > r30_pkg::bcnt_t'(r30_pkg::MAX_BITS))
		? r30_pkg::bcnt_t'(r30_pkg::MAX_BITS) : bit_count;
	assign cnt_last = (cnt_q == r30_pkg::cnt_t'(1));
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		ring_cmd_o = '0;
		mix_cmd_o  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ring_cmd_o.clr_acc = 1'b1;
					if (cmd == r30_pkg::CMD_RESEED) begin
						mix_cmd_o.init = 1'b1;
						if (r30_pkg::MIX_CELLS > 0) begin
							cnt_d   = r30_pkg::cnt_t'(r30_pkg::MIX_CELLS);
							state_d = S_FILL;
						end else begin
							state_d = S_LOAD;
						end
					end else if (req_bits == '0) begin
						state_d = S_FINISH;
					end else begin
						cnt_d   = r30_pkg::cnt_t'(req_bits);
						state_d = S_STEP;
					end
				end
			end
			S_FILL: begin
				mix_cmd_o.run = 1'b1;
				if (mix_st_i.bit_valid) begin
					ring_cmd_o.fill = 1'b1;
					cnt_d = cnt_q - r30_pkg::cnt_t'(1);
					if (cnt_last) begin
						state_d = S_LOAD;
					end
				end
			end
			S_LOAD: begin
				ring_cmd_o.load_seed = 1'b1;
				state_d = S_FIX;
			end
			S_FIX: begin
				// a uniform row would die out: plant the middle cell (no change on an all-one row)
				ring_cmd_o.set_mid = ring_st_i.row_empty || ring_st_i.all_one;
				cnt_d   = r30_pkg::cnt_t'(r30_pkg::WARM_STEPS);
				state_d = S_WARM;
			end
			S_WARM: begin
				ring_cmd_o.step = 1'b1;
				cnt_d = cnt_q - r30_pkg::cnt_t'(1);
				if (cnt_last) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (ring_st_i.row_empty) begin
					ring_cmd_o.set_mid = 1'b1;
					cnt_d   = r30_pkg::cnt_t'(r30_pkg::WARM_STEPS);
					state_d = S_WARM2;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_WARM2: begin
				ring_cmd_o.step = 1'b1;
				cnt_d = cnt_q - r30_pkg::cnt_t'(1);
				if (cnt_last) begin
					state_d = S_FINISH;
				end
			end
			S_STEP: begin
				ring_cmd_o.gen = 1'b1;
				cnt_d = cnt_q - r30_pkg::cnt_t'(1);
				if (cnt_last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				// hold until the output register is free
				if (!ring_st_i.out_full || !out_stall) begin
					ring_cmd_o.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

FILE: bench/rule30_ring_random_generator_test.sv
// ----------------------------------------------------------------------------
// rule30_ring_random_generator_test
// Self-checking bench for the Rule 30 ring random generator. A bit-true
// software copy of the cell ring and its splitmix64 fill predicts every result
// word; directed words cover the seed extremes, empty and oversized bit counts
// and a generate before the first reseed, then random reseed/generate runs go
// through three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module rule30_ring_random_generator_test;

	localparam int unsigned RING_W   = r30_pkg::WIDTH;
	localparam int unsigned RING_MID = RING_W / 2;
	localparam int unsigned RING_TAP = RING_W / 8;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           cfg_we = 1'b0;
	logic [63:0]    cfg_wdata = '0;
	logic           in_valid = 1'b0;
	logic           in_stall;
	logic           cmd = r30_pkg::CMD_RESEED;
	r30_pkg::bcnt_t bit_count = '0;
	logic           out_valid;
	logic           out_stall = 1'b0;
	logic [63:0]    value;

	// predicted machine state
	logic [RING_W-1:0] ring_cells = '0;
	logic [63:0]       mix_state = '0;
	logic [63:0]       seed_shadow = '0;

	logic [63:0] expected_values[$];
	int          mismatch_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	rule30_ring_random_generator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.bit_count (bit_count),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [RING_W-1:0] rule30_step(input logic [RING_W-1:0] c);
		logic [RING_W-1:0] left_n;
		logic [RING_W-1:0] right_n;
		left_n  = {c[RING_W-2:0], c[RING_W-1]};
		right_n = {c[0], c[RING_W-1:1]};
		return left_n ^ (c | right_n);
	endfunction

	task automatic reload_ring();
		logic [63:0] z;
		mix_state = seed_shadow;
		for (int i = 0; i < RING_W; i++) begin
			if (i < 64) begin
				ring_cells[i] = seed_shadow[i];
			end else begin
				mix_state = mix_state + r30_pkg::MIX_GOLDEN;
				z = mix_state;
				z = (z ^ (z >> 30)) * r30_pkg::MIX_C1;
				z = (z ^ (z >> 27)) * r30_pkg::MIX_C2;
				z = z ^ (z >> 31);
				ring_cells[i] = z[0];
			end
		end
		// a uniform row would die out, so plant one live cell (no change when all one)
		if (ring_cells == '0 || &ring_cells)
			ring_cells[RING_MID] = 1'b1;
		repeat (RING_W / 2) ring_cells = rule30_step(ring_cells);
		if (ring_cells == '0) begin
			ring_cells[RING_MID] = 1'b1;
			repeat (RING_W / 2) ring_cells = rule30_step(ring_cells);
		end
	endtask

	task automatic draw_bits(input r30_pkg::bcnt_t n, output logic [63:0] bits);
		int unsigned count;
		count = (n > 64) ? 64 : n;
		bits = '0;
		repeat (count) begin
			ring_cells = rule30_step(ring_cells);
			bits = {bits[62:0], ring_cells[RING_MID] ^ ring_cells[RING_MID - RING_TAP]
				^ ring_cells[RING_MID + RING_TAP]};
		end
	endtask

	// receiver back-pressure
	always @(posedge clk)
		out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (expected_values.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, value);
				mismatch_count++;
			end else begin
				if (value !== expected_values[0]) begin
					$display("%0t: value expected %h, actual %h", $time,
						expected_values[0], value);
					mismatch_count++;
				end
				void'(expected_values.pop_front());
			end
		end
	end

	// call just after a rising edge; leaves in_valid high
	task automatic send_word(input logic op, input r30_pkg::bcnt_t n);
		logic [63:0] bits;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= op;
		bit_count <= n;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		if (op == r30_pkg::CMD_RESEED) begin
			reload_ring();
			expected_values.push_back('0);
		end else begin
			draw_bits(n, bits);
			expected_values.push_back(bits);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_values.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_seed(input logic [63:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we      <= 1'b0;
		seed_shadow = v;
	endtask

	task automatic test_generate_before_reseed();
		send_word(r30_pkg::CMD_GENERATE, 7'd64);
		send_word(r30_pkg::CMD_GENERATE, 7'd0);
		drain();
	endtask

	task automatic test_seed_extremes();
		write_seed(64'h0);
		send_word(r30_pkg::CMD_RESEED, 7'd0);
		send_word(r30_pkg::CMD_GENERATE, 7'd64);
		drain();
		write_seed({64{1'b1}});
		send_word(r30_pkg::CMD_RESEED, 7'd127);
		send_word(r30_pkg::CMD_GENERATE, 7'd64);
		drain();
		write_seed(64'h8000_0000_0000_0001);
		send_word(r30_pkg::CMD_RESEED, 7'd0);
		send_word(r30_pkg::CMD_GENERATE, 7'd33);
		drain();
	endtask

	task automatic test_bit_counts();
		r30_pkg::bcnt_t counts[8] = '{7'd0, 7'd1, 7'd2, 7'd63, 7'd64, 7'd65, 7'd127,
			7'd100};
		write_seed({$urandom, $urandom});
		send_word(r30_pkg::CMD_RESEED, 7'd0);
		foreach (counts[i]) send_word(r30_pkg::CMD_GENERATE, counts[i]);
		drain();
	endtask

	task automatic test_random_traffic(input int words, input int idle_pct,
		input int stall_pct);
		int sent;
		int run_len;
		int pick;
		r30_pkg::bcnt_t n;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < words) begin
			pick = $urandom_range(7);
			if (pick == 0)
				write_seed(64'h0);
			else if (pick == 1)
				write_seed({64{1'b1}});
			else
				write_seed({$urandom, $urandom});
			send_word(r30_pkg::CMD_RESEED, r30_pkg::bcnt_t'($urandom_range(127)));
			sent++;
			run_len = $urandom_range(20, 50);
			for (int k = 0; k < run_len && sent < words; k++) begin
				pick = $urandom_range(99);
				if (pick < 3) begin
					send_word(r30_pkg::CMD_RESEED, r30_pkg::bcnt_t'($urandom_range(127)));
				end else begin
					if (pick < 8)
						n = 7'd0;
					else if (pick < 15)
						n = r30_pkg::bcnt_t'($urandom_range(65, 127));
					else if (pick < 22)
						n = 7'd64;
					else
						n = r30_pkg::bcnt_t'($urandom_range(1, 64));
					send_word(r30_pkg::CMD_GENERATE, n);
				end
				sent++;
			end
			drain();
		end
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_generate_before_reseed();
		test_seed_extremes();
		test_bit_counts();
		test_random_traffic(430, 15, 67);
		test_random_traffic(430, 67, 15);
		test_random_traffic(440, 0, 0);
		if (mismatch_count == 0)
			$display("rule30_ring_random_generator: match");
		else
			$display("rule30_ring_random_generator: mismatch");
		$finish;
	end

	initial begin
		#16_000_000;
		$display("rule30_ring_random_generator: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
rtl/r30_pkg.sv
rtl/r30_mixer.sv
rtl/r30_ring.sv
rtl/r30_ctrl.sv
rtl/rule30_ring_random_generator.sv
bench/rule30_ring_random_generator_test.sv
